FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the timer queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OTQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

FILE: sv/otq_pkg.sv
// Types, codes and defaults of the ordered timer queue.
`timescale 1ns / 1ps
package otq_pkg;

  localparam int DEFAULT_NUM_TIMERS = 16;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_TIMED_OUT = 3'd1;
  localparam logic [2:0] EV_STOPPED   = 3'd2;
  localparam logic [2:0] EV_EXPIRED   = 3'd3;
  localparam logic [2:0] EV_TICK_DONE = 3'd4;
  localparam logic [2:0] EV_QUERY     = 3'd5;

  localparam logic [1:0] CFG_SCHED_LAT = 2'd0;
  localparam logic [1:0] CFG_SHOT_LAT  = 2'd1;
  localparam logic [1:0] CFG_WALL_OFS  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  timer_index;
    logic [63:0] start_value;
    logic [63:0] reload_interval;
    logic        relative;
    logic [63:0] now_count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [3:0]  which_timer;
    logic [63:0] expiry_date;
    logic [63:0] remaining;
    logic [63:0] period;
    logic        shot_valid;
    logic [31:0] shot_delay;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] sched_latency;
    logic [31:0] shot_latency;
    logic [63:0] abs_offset;
  } cfg_t;

endpackage

FILE: sv/otq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module otq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = otq_pkg::DEFAULT_NUM_TIMERS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: sv/otq_fifo.sv
// Two-entry queue used between the front, the engine and the result port.
`timescale 1ns / 1ps
module otq_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: sv/otq_front.sv
// Front end: accepts commands, drops out-of-range timer indexes, queues the rest.
`timescale 1ns / 1ps
module otq_front #(
  parameter int NUM_TIMERS = otq_pkg::DEFAULT_NUM_TIMERS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [1:0]    in_kind,
  input  logic [3:0]    in_timer_index,
  input  logic [63:0]   in_start_value,
  input  logic [63:0]   in_reload_interval,
  input  logic          in_relative,
  input  logic [63:0]   in_now_count,
  output logic          cmd_valid,
  output otq_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  otq_pkg::cmd_t cmd_in;
  logic          keep;
  logic          q_full;
  logic          q_empty;

  assign cmd_in.kind            = in_kind;
  assign cmd_in.timer_index     = in_timer_index;
  assign cmd_in.start_value     = in_start_value;
  assign cmd_in.reload_interval = in_reload_interval;
  assign cmd_in.relative        = in_relative;
  assign cmd_in.now_count       = in_now_count;

  // a tick names no timer; anything else must name an existing one
  assign keep = (in_kind == otq_pkg::KIND_TICK) ||
                (32'(in_timer_index) < 32'(NUM_TIMERS));

  assign in_full   = q_full;
  assign cmd_valid = !q_empty;

  otq_fifo #(.WIDTH($bits(otq_pkg::cmd_t))) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push && keep),
    .din  (cmd_in),
    .full (q_full),
    .pop  (cmd_pop),
    .dout (cmd),
    .empty(q_empty)
  );

endmodule

FILE: sv/otq_div.sv
// Bit-serial restoring divider, remainder only, one quotient bit per cycle.
`timescale 1ns / 1ps
module otq_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] rem
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [64:0] rem_r;
  logic [63:0] dvd_r;
  logic [63:0] dvs_r;
  logic [64:0] trial;

  assign trial = {rem_r[63:0], dvd_r[63]};
  assign done  = done_r;
  assign rem   = rem_r[63:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= (trial >= {1'b0, dvs_r}) ? trial - {1'b0, dvs_r} : trial;
      dvd_r <= {dvd_r[62:0], 1'b0};
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/otq_engine.sv
// Back end: runs one command at a time over the timer tables and builds results.
`timescale 1ns / 1ps
module otq_engine #(
  parameter int NUM_TIMERS = otq_pkg::DEFAULT_NUM_TIMERS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  otq_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  otq_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output otq_pkg::res_t res
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PREP     = 4'd1;
  localparam logic [3:0] S_DISP     = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_SCAN_END = 4'd4;
  localparam logic [3:0] S_POST     = 4'd5;
  localparam logic [3:0] S_RDW      = 4'd6;
  localparam logic [3:0] S_TRD      = 4'd7;
  localparam logic [3:0] S_TREARM   = 4'd8;
  localparam logic [3:0] S_TDIV     = 4'd9;
  localparam logic [3:0] S_TADD     = 4'd10;
  localparam logic [3:0] S_TFIN     = 4'd11;
  localparam logic [3:0] S_SHOT     = 4'd12;
  localparam logic [3:0] S_EMIT     = 4'd13;

  logic [3:0]            state_r;
  logic [3:0]            emit_next_r;
  otq_pkg::cmd_t         cmd_r;
  otq_pkg::res_t         res_r;
  logic [32:0]           lat_sum_r;
  logic [63:0]           date_r;
  logic [63:0]           x_r;
  logic [63:0]           head_r;
  logic [NUM_TIMERS-1:0] armed_r;
  logic [NUM_TIMERS-1:0] written_r;
  logic [NUM_TIMERS-1:0] done_r;
  logic [IW-1:0]         scan_cnt_r;
  logic                  rd_vld_r;
  logic [IW-1:0]         rd_idx_r;
  logic                  ba_vld_r;
  logic [IW-1:0]         ba_idx_r;
  logic [63:0]           ba_due_r;
  logic                  bb_vld_r;
  logic [IW-1:0]         bb_idx_r;
  logic [63:0]           bb_due_r;
  logic [IW-1:0]         exp_idx_r;
  logic [63:0]           exp_date_r;
  logic [63:0]           exp_ival_r;
  logic [63:0]           step_r;
  logic [63:0]           adj_r;
  logic                  adj_nz_r;
  logic                  sat_r;

  logic [IW-1:0] t_idx;
  logic [IW-1:0] raddr;
  logic [63:0]   due_q;
  logic [63:0]   rel_q;
  logic [63:0]   due_eff;
  logic [63:0]   rel_eff;
  logic          timed_out;
  logic          start_wr;
  logic          due_we;
  logic [IW-1:0] waddr;
  logic [63:0]   due_wdata;
  logic [64:0]   fin_sum;
  logic [64:0]   adj_sum;
  logic [63:0]   shot_diff;
  logic [31:0]   shot_val;
  logic          a_ok;
  logic          div_start;
  logic          div_done;
  logic [63:0]   div_rem;
  logic          heading;

  function automatic otq_pkg::res_t mk_res(
    input logic [2:0] ev, input logic [3:0] which, input logic [63:0] date,
    input logic [63:0] rem, input logic [63:0] per, input logic sv, input logic lst);
    otq_pkg::res_t r;
    r.event_res   = ev;
    r.which_timer = which;
    r.expiry_date = date;
    r.remaining   = rem;
    r.period      = per;
    r.shot_valid  = sv;
    r.shot_delay  = '0;
    r.last        = lst;
    return r;
  endfunction

  assign t_idx     = IW'(cmd_r.timer_index);
  assign due_eff   = written_r[rd_idx_r] ? due_q : '1;
  assign rel_eff   = written_r[rd_idx_r] ? rel_q : '0;
  assign timed_out = !cmd_r.relative && (date_r <= cmd_r.now_count);
  assign start_wr  = (state_r == S_DISP) && (cmd_r.kind == otq_pkg::KIND_START) && !timed_out;
  assign due_we    = start_wr || (state_r == S_TFIN);
  assign waddr     = (state_r == S_TFIN) ? exp_idx_r : t_idx;
  assign fin_sum   = {1'b0, exp_date_r} + {1'b0, step_r};
  assign adj_sum   = {1'b0, step_r} + {1'b0, adj_r};
  assign due_wdata = (state_r == S_TFIN) ? ((sat_r || fin_sum[64]) ? '1 : fin_sum[63:0])
                                         : date_r;
  assign shot_diff = head_r - x_r;
  assign shot_val  = (x_r >= head_r) ? 32'd0 :
                     ((|shot_diff[63:32]) ? '1 : shot_diff[31:0]);
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign res_push  = (state_r == S_EMIT) && !res_full;
  assign res       = res_r;
  assign div_start = (state_r == S_TREARM) && (exp_ival_r != '0) &&
                     (exp_date_r < cmd_r.now_count);
  assign heading   = armed_r[t_idx] && bb_vld_r && (bb_idx_r == t_idx);

  always_comb begin
    if (state_r == S_SCAN) begin
      raddr = scan_cnt_r;
    end else if ((state_r == S_POST) && (cmd_r.kind == otq_pkg::KIND_TICK)) begin
      raddr = ba_idx_r;
    end else begin
      raddr = t_idx;
    end
  end

  // which timers compete for the "next in line" slot of this scan
  always_comb begin
    if (cmd_r.kind == otq_pkg::KIND_TICK) begin
      a_ok = !done_r[rd_idx_r];
    end else if (cmd_r.kind == otq_pkg::KIND_STOP) begin
      a_ok = (rd_idx_r != t_idx);
    end else begin
      a_ok = 1'b1;
    end
  end

  otq_ram #(.WIDTH(64), .DEPTH(NUM_TIMERS)) u_due_ram (
    .clk(clk), .we(due_we), .waddr(waddr), .wdata(due_wdata),
    .raddr(raddr), .rdata(due_q)
  );

  otq_ram #(.WIDTH(64), .DEPTH(NUM_TIMERS)) u_rel_ram (
    .clk(clk), .we(start_wr), .waddr(t_idx), .wdata(cmd_r.reload_interval),
    .raddr(raddr), .rdata(rel_q)
  );

  otq_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(cmd_r.now_count - exp_date_r), .divisor(exp_ival_r),
    .done(div_done), .rem(div_rem)
  );

  always_ff @(posedge clk) begin
    lat_sum_r <= {1'b0, cfg.sched_latency} + {1'b0, cfg.shot_latency};
    rd_idx_r  <= raddr;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emit_next_r <= S_IDLE;
      armed_r     <= '0;
      written_r   <= '0;
      done_r      <= '0;
      rd_vld_r    <= 1'b0;
      ba_vld_r    <= 1'b0;
      bb_vld_r    <= 1'b0;
      scan_cnt_r  <= '0;
    end else begin
      rd_vld_r <= (state_r == S_SCAN);

      // fold the entry read last cycle into the two running minimums
      if (rd_vld_r && ((state_r == S_SCAN) || (state_r == S_SCAN_END)) &&
          armed_r[rd_idx_r]) begin
        if (!bb_vld_r || (due_eff < bb_due_r)) begin
          bb_vld_r <= 1'b1;
          bb_idx_r <= rd_idx_r;
          bb_due_r <= due_eff;
        end
        if (a_ok && (!ba_vld_r || (due_eff < ba_due_r))) begin
          ba_vld_r <= 1'b1;
          ba_idx_r <= rd_idx_r;
          ba_due_r <= due_eff;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          x_r    <= cmd_r.now_count + 64'(lat_sum_r);
          date_r <= cmd_r.relative ? cmd_r.start_value + cmd_r.now_count
                                   : cmd_r.start_value - cfg.abs_offset;
          if (cmd_r.kind == otq_pkg::KIND_START) armed_r[t_idx] <= 1'b0;
          state_r <= S_DISP;
        end
        S_DISP: begin
          scan_cnt_r <= '0;
          ba_vld_r   <= 1'b0;
          bb_vld_r   <= 1'b0;
          unique case (cmd_r.kind)
            otq_pkg::KIND_START: begin
              if (timed_out) begin
                res_r <= mk_res(otq_pkg::EV_TIMED_OUT, cmd_r.timer_index, date_r,
                                '0, '0, 1'b0, 1'b1);
                emit_next_r <= S_IDLE;
                state_r     <= S_EMIT;
              end else begin
                armed_r[t_idx]   <= 1'b1;
                written_r[t_idx] <= 1'b1;
                state_r          <= S_SCAN;
              end
            end
            otq_pkg::KIND_STOP: state_r <= S_SCAN;
            otq_pkg::KIND_TICK: begin
              done_r  <= '0;
              state_r <= S_SCAN;
            end
            otq_pkg::KIND_QUERY: state_r <= S_RDW;
            default: state_r <= S_IDLE;
          endcase
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + IW'(1);
          if (scan_cnt_r == LAST_IDX) state_r <= S_SCAN_END;
        end
        S_SCAN_END: state_r <= S_POST;
        S_POST: begin
          emit_next_r <= S_IDLE;
          unique case (cmd_r.kind)
            otq_pkg::KIND_START: begin
              if (bb_vld_r && (bb_idx_r == t_idx)) begin
                head_r  <= bb_due_r;
                res_r   <= mk_res(otq_pkg::EV_STARTED, cmd_r.timer_index, date_r, '0,
                                  cmd_r.reload_interval, 1'b1, 1'b1);
                state_r <= S_SHOT;
              end else begin
                res_r   <= mk_res(otq_pkg::EV_STARTED, cmd_r.timer_index, date_r, '0,
                                  cmd_r.reload_interval, 1'b0, 1'b1);
                state_r <= S_EMIT;
              end
            end
            otq_pkg::KIND_TICK: begin
              if (ba_vld_r &&
                  ((ba_due_r - 64'(cfg.sched_latency)) <= cmd_r.now_count)) begin
                exp_idx_r         <= ba_idx_r;
                exp_date_r        <= ba_due_r;
                armed_r[ba_idx_r] <= 1'b0;
                done_r[ba_idx_r]  <= 1'b1;
                state_r           <= S_TRD;
              end else begin
                head_r  <= bb_due_r;
                res_r   <= mk_res(otq_pkg::EV_TICK_DONE, 4'd0,
                                  bb_vld_r ? bb_due_r : 64'd0, '0, '0, bb_vld_r, 1'b1);
                state_r <= bb_vld_r ? S_SHOT : S_EMIT;
              end
            end
            default: state_r <= S_RDW;
          endcase
        end
        S_RDW: begin
          emit_next_r <= S_IDLE;
          if (cmd_r.kind == otq_pkg::KIND_QUERY) begin
            res_r <= mk_res(otq_pkg::EV_QUERY, cmd_r.timer_index, due_eff,
                            (due_eff < cmd_r.now_count) ? 64'd1 : due_eff - cmd_r.now_count,
                            rel_eff, 1'b0, 1'b1);
            state_r <= S_EMIT;
          end else begin
            armed_r[t_idx] <= 1'b0;
            head_r         <= ba_due_r;
            res_r <= mk_res(otq_pkg::EV_STOPPED, cmd_r.timer_index, due_eff, '0,
                            rel_eff, heading && ba_vld_r, 1'b1);
            state_r <= (heading && ba_vld_r) ? S_SHOT : S_EMIT;
          end
        end
        S_TRD: begin
          exp_ival_r  <= rel_eff;
          res_r <= mk_res(otq_pkg::EV_EXPIRED, 4'(exp_idx_r), exp_date_r, '0,
                          rel_eff, 1'b0, 1'b0);
          emit_next_r <= S_TREARM;
          state_r     <= S_EMIT;
        end
        S_TREARM: begin
          sat_r <= 1'b0;
          if (exp_ival_r == '0) begin
            scan_cnt_r <= '0;
            ba_vld_r   <= 1'b0;
            bb_vld_r   <= 1'b0;
            state_r    <= S_SCAN;
          end else if (exp_date_r >= cmd_r.now_count) begin
            step_r  <= exp_ival_r;
            state_r <= S_TFIN;
          end else begin
            step_r  <= cmd_r.now_count - exp_date_r;
            state_r <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            adj_nz_r <= (div_rem != '0);
            adj_r    <= exp_ival_r - div_rem;
            state_r  <= S_TADD;
          end
        end
        S_TADD: begin
          // round the catch-up step up to a whole number of intervals
          if (adj_nz_r) begin
            step_r <= adj_sum[63:0];
            sat_r  <= adj_sum[64];
          end
          state_r <= S_TFIN;
        end
        S_TFIN: begin
          armed_r[exp_idx_r] <= 1'b1;
          scan_cnt_r <= '0;
          ba_vld_r   <= 1'b0;
          bb_vld_r   <= 1'b0;
          state_r    <= S_SCAN;
        end
        S_SHOT: begin
          res_r.shot_delay <= shot_val;
          state_r          <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_full) state_r <= emit_next_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/ordered_timer_queue.sv
// Top level of the ordered timer queue: ports, configuration registers, result queue.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_push / in_full      | kind, timer_index, start_value,
//          |           |                        | reload_interval, relative, now_count
//  out_    | output    | out_empty / out_pop    | event_res ... last, one result each
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  Commands run one at a time in the engine; each scan of the timer table reads it
//  through the date RAM read port. A query and a timed-out start need no scan; a start
//  and a stop take one scan each, plus a shot step when a start becomes the head or a
//  stop leaves a new shot; a tick takes (E + 1) scans for E expiries, plus a division
//  for each periodic timer that fell behind.
//  Reset is synchronous and clears control state and all armed bits.
//  A full result queue stalls the engine; the two-entry command queue accepts until full.
`timescale 1ns / 1ps
module ordered_timer_queue #(
  parameter int NUM_TIMERS = otq_pkg::DEFAULT_NUM_TIMERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_timer_index,
  input  logic [63:0] in_start_value,
  input  logic [63:0] in_reload_interval,
  input  logic        in_relative,
  input  logic [63:0] in_now_count,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_event_res,
  output logic [3:0]  out_which_timer,
  output logic [63:0] out_expiry_date,
  output logic [63:0] out_remaining,
  output logic [63:0] out_period,
  output logic        out_shot_valid,
  output logic [31:0] out_shot_delay,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  otq_pkg::cfg_t cfg_r;
  otq_pkg::cmd_t cmd;
  otq_pkg::res_t res;
  otq_pkg::res_t res_out;
  logic          cmd_valid;
  logic          cmd_pop;
  logic          res_push;
  logic          res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        otq_pkg::CFG_SCHED_LAT: cfg_r.sched_latency <= cfg_data[31:0];
        otq_pkg::CFG_SHOT_LAT:  cfg_r.shot_latency  <= cfg_data[31:0];
        otq_pkg::CFG_WALL_OFS:  cfg_r.abs_offset    <= cfg_data;
        default: ;
      endcase
    end
  end

  otq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_timer_index    (in_timer_index),
    .in_start_value    (in_start_value),
    .in_reload_interval(in_reload_interval),
    .in_relative       (in_relative),
    .in_now_count      (in_now_count),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop)
  );

  otq_engine #(.NUM_TIMERS(NUM_TIMERS)) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  otq_fifo #(.WIDTH($bits(otq_pkg::res_t))) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (out_pop),
    .dout (res_out),
    .empty(out_empty)
  );

  assign out_event_res   = res_out.event_res;
  assign out_which_timer = res_out.which_timer;
  assign out_expiry_date = res_out.expiry_date;
  assign out_remaining   = res_out.remaining;
  assign out_period      = res_out.period;
  assign out_shot_valid  = res_out.shot_valid;
  assign out_shot_delay  = res_out.shot_delay;
  assign out_last        = res_out.last;

endmodule

FILE: sv/otq_checker.sv
// Port-level checks of the ordered timer queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module otq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_event_res,
  input logic [3:0]  out_which_timer,
  input logic [63:0] out_expiry_date,
  input logic [63:0] out_remaining,
  input logic [63:0] out_period,
  input logic        out_shot_valid,
  input logic [31:0] out_shot_delay,
  input logic        out_last
);

  `OTQ_ASSERT_NOW(a_tick_done_shape, !out_empty && (out_event_res == otq_pkg::EV_TICK_DONE), out_last && (out_which_timer == 4'd0) && (out_remaining == 64'd0) && (out_period == 64'd0))
  `OTQ_ASSERT_NOW(a_expiry_shape, !out_empty && (out_event_res == otq_pkg::EV_EXPIRED), !out_last && !out_shot_valid && (out_remaining == 64'd0))
  `OTQ_ASSERT_NOW(a_no_shot_no_delay, !out_empty && !out_shot_valid, out_shot_delay == 32'd0)
  `OTQ_ASSERT_NEXT(a_result_holds, !out_empty && !out_pop, !out_empty && $stable(out_expiry_date))

endmodule

bind ordered_timer_queue otq_checker u_otq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_event_res  (out_event_res),
  .out_which_timer(out_which_timer),
  .out_expiry_date(out_expiry_date),
  .out_remaining  (out_remaining),
  .out_period     (out_period),
  .out_shot_valid (out_shot_valid),
  .out_shot_delay (out_shot_delay),
  .out_last       (out_last)
);
